// ----- sv/first_person_camera_update_defines.svh -----
// ----------------------------------------------------------------------------
// First-person camera update: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_PERSON_CAMERA_UPDATE_DEFINES_SVH
`define FIRST_PERSON_CAMERA_UPDATE_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define FPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define FPC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- sv/fpc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpc_pkg
// Types, constants and the micro-program of the first-person camera update.
// ----------------------------------------------------------------------------
package fpc_pkg;

  // Number formats
  localparam int ANGLE_BITS    = 32;
  localparam int POS_FRAC_BITS = 16;

  localparam logic [31:0] ANG_MASK = 32'(~((64'd1 << (32 - ANGLE_BITS)) - 64'd1));
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Sine polynomial coefficients, Q30
  localparam logic [30:0] A1  = 31'd1686629713;
  localparam logic [30:0] A3  = 31'd693598668;
  localparam logic [30:0] A5  = 31'd85569306;
  localparam logic [30:0] A7  = 31'd5026991;
  localparam logic [30:0] A9  = 31'd172272;
  localparam logic [30:0] A11 = 31'd3864;

  // 0.003 rad per pixel in binary angle units
  localparam logic [20:0] MOUSE_STEP = 21'd2050696;
  // 89 degrees in binary angle units
  localparam logic [31:0] PITCH_LIM =
    32'(((64'd89 << 32) + 64'd180) / 64'd360) & ANG_MASK;

  localparam logic [31:0] EYE_RESET =
    32'(((64'd185 << POS_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [9:0]  MOVE_DIV_RESET = 10'd25;

  // Move step is |S| / (div * 2^(30 - frac)); look offset is floor(L*|P|/2^26)*10/816
  localparam int MOVE_SHIFT = 30 - POS_FRAC_BITS;
  localparam int LOOK_SHIFT = 26;
  localparam logic [9:0] LOOK_DIVISOR = 10'd816;

  // Iterative divider
  localparam int DIV_W       = 40;
  localparam int DIV_DEN_W   = 10;
  localparam int DIV_STEP    = 4;
  localparam int DIV_ITERS   = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W   = $clog2(DIV_ITERS);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_YAW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PITCH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOK_DISTANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DIVIDER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_MOUSE_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_MOUSE_Y  = 3'd6;

  // Channel payloads
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        mouse_x;
    logic [15:0]        mouse_y;
    logic               key_front;
    logic               key_back;
    logic               key_right;
    logic               key_left;
    logic               force_eye_height;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          wdata;
  } cfg_wr_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_SIN_LD,    // load reduced angle of source arg
    OP_MUL_XX,    // x * x
    OP_LD_X2,     // x2 from product, t from A11
    OP_MUL_X2T,   // x2 * t
    OP_SUB_T,     // t = coef(arg) - product
    OP_MUL_XT,    // x * t
    OP_SIN_ST,    // clamp, sign and store sine into slot arg
    OP_DIV,       // start divide for move axis arg, or look offset
    OP_MOVE,      // new position of axis arg
    OP_ANG_YAW,   // yaw update from mouse x
    OP_ANG_PITCH, // pitch update from mouse y, clamped
    OP_MUL_PC,    // |sin yaw or cos yaw| * |cos pitch|
    OP_MUL_L,     // look distance times factor magnitude
    OP_TGT,       // look target of axis arg
    OP_DONE,      // load result register
    OP_SKIP       // jump to next segment
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] arg;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic in_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  // Sine slots and angle sources share one code
  localparam logic [2:0] SRC_SIN_YAW   = 3'd0;
  localparam logic [2:0] SRC_COS_YAW   = 3'd1;
  localparam logic [2:0] SRC_SIN_PITCH = 3'd2;
  localparam logic [2:0] SRC_COS_PITCH = 3'd3;

  localparam logic [2:0] AXIS_X    = 3'd0;
  localparam logic [2:0] AXIS_Y    = 3'd1;
  localparam logic [2:0] AXIS_Z    = 3'd2;
  localparam logic [2:0] DIV_LOOK  = 3'd3;

  localparam logic [2:0] FAC_PROD  = 3'd0;
  localparam logic [2:0] FAC_PITCH = 3'd1;

  localparam int PC_W = 8;
  localparam logic [3:0] SEG_MOVE = 4'd3;
  localparam logic [3:0] SEG_LOOK = 4'd8;

  // Micro-program: 16-step segments. Segments 0-2 and 4-7 are sines,
  // segment 3 moves and turns, segment 8 builds the look target.
  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    logic [3:0] seg;
    logic [3:0] st;
    uop_t       u;
    seg   = pc[7:4];
    st    = pc[3:0];
    u.op  = OP_NOP;
    u.arg = 3'd0;
    if (seg == SEG_MOVE) begin
      case (st)
        4'd0:    begin u.op = OP_DIV;  u.arg = AXIS_X; end
        4'd1:    begin u.op = OP_MOVE; u.arg = AXIS_X; end
        4'd2:    begin u.op = OP_DIV;  u.arg = AXIS_Y; end
        4'd3:    begin u.op = OP_MOVE; u.arg = AXIS_Y; end
        4'd4:    begin u.op = OP_DIV;  u.arg = AXIS_Z; end
        4'd5:    begin u.op = OP_MOVE; u.arg = AXIS_Z; end
        4'd6:    u.op = OP_ANG_YAW;
        4'd7:    u.op = OP_ANG_PITCH;
        default: u.op = OP_SKIP;
      endcase
    end else if (seg == SEG_LOOK) begin
      case (st)
        4'd0:    begin u.op = OP_MUL_PC; u.arg = SRC_SIN_YAW; end
        4'd1:    begin u.op = OP_MUL_L;  u.arg = FAC_PROD; end
        4'd2:    begin u.op = OP_DIV;    u.arg = DIV_LOOK; end
        4'd3:    begin u.op = OP_TGT;    u.arg = AXIS_X; end
        4'd4:    begin u.op = OP_MUL_L;  u.arg = FAC_PITCH; end
        4'd5:    begin u.op = OP_DIV;    u.arg = DIV_LOOK; end
        4'd6:    begin u.op = OP_TGT;    u.arg = AXIS_Y; end
        4'd7:    begin u.op = OP_MUL_PC; u.arg = SRC_COS_YAW; end
        4'd8:    begin u.op = OP_MUL_L;  u.arg = FAC_PROD; end
        4'd9:    begin u.op = OP_DIV;    u.arg = DIV_LOOK; end
        4'd10:   begin u.op = OP_TGT;    u.arg = AXIS_Z; end
        4'd11:   u.op = OP_DONE;
        default: u.op = OP_NOP;
      endcase
    end else if (seg < SEG_LOOK) begin
      case (st) inside
        4'd0:    begin u.op = OP_SIN_LD; u.arg = {1'b0, seg[1:0]}; end
        4'd1:    u.op = OP_MUL_XX;
        4'd2:    u.op = OP_LD_X2;
        4'd3, 4'd5, 4'd7, 4'd9, 4'd11:
                 u.op = OP_MUL_X2T;
        4'd4, 4'd6, 4'd8, 4'd10, 4'd12:
                 begin u.op = OP_SUB_T; u.arg = 3'(st[3:1] - 3'd2); end
        4'd13:   u.op = OP_MUL_XT;
        4'd14:   begin u.op = OP_SIN_ST; u.arg = {1'b0, seg[1:0]}; end
        default: u.op = OP_SKIP;
      endcase
    end
    return u;
  endfunction

  // Horner coefficients from A9 down to A1
  function automatic logic [30:0] sin_coef(logic [2:0] k);
    logic [30:0] c;
    case (k)
      3'd0:    c = A9;
      3'd1:    c = A7;
      3'd2:    c = A5;
      3'd3:    c = A3;
      default: c = A1;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/fpc_stream_if.sv -----
// ----------------------------------------------------------------------------
// fpc_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface fpc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/fpc_div.sv -----
// ----------------------------------------------------------------------------
// fpc_div
// Restoring unsigned divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module fpc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [fpc_pkg::DIV_W-1:0]      dividend_i,
  input  logic [fpc_pkg::DIV_DEN_W-1:0]  divisor_i,
  output logic [fpc_pkg::DIV_W-1:0]      quot_o,
  output logic                           done_o
);
  import fpc_pkg::*;

  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic                 last;

  assign last = (cnt_q == DIV_CNT_W'(DIV_ITERS - 1));

  // Shift dividend bits into the remainder, quotient bits into the low end
  always_comb begin
    logic [DIV_DEN_W:0] r;
    logic               ge;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_STEP; i++) begin
      r     = {rem_d, quo_d[DIV_W-1]};
      ge    = (r >= {1'b0, den_q});
      quo_d = {quo_d[DIV_W-2:0], ge};
      rem_d = ge ? DIV_DEN_W'(r - {1'b0, den_q}) : r[DIV_DEN_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// ----- sv/fpc_dp.sv -----
// ----------------------------------------------------------------------------
// fpc_dp
// Camera datapath: angle state, shared multiplier, sine steps, divider.
// ----------------------------------------------------------------------------
module fpc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpc_pkg::dp_cmd_t    cmd_i,
  output fpc_pkg::dp_stat_t   stat_o,
  input  fpc_pkg::in_item_t   in_item_i,
  input  logic                cfg_we_i,
  input  fpc_pkg::cfg_wr_t    cfg_i,
  output fpc_pkg::out_item_t  out_item_o
);
  import fpc_pkg::*;

  // Angle and configuration state
  logic [31:0] yaw_q, pitch_q;
  logic [15:0] lmx_q, lmy_q;
  logic [30:0] look_dist_q;
  logic [31:0] eye_q;
  logic [9:0]  mdiv_q;

  // Working registers
  in_item_t           item_q;
  logic [30:0]        x_q, x2_q, t_q;
  logic [1:0]         quad_q;
  logic [61:0]        prod_q;
  logic signed [31:0] sy_q, cy_q, sp_q, cp_q;
  logic               sgn_q;
  logic [31:0]        nx_q, ny_q, nz_q, tx_q, ty_q, tz_q;
  out_item_t          out_q;

  op_e         op;
  logic [2:0]  arg;
  logic [31:0] ang;
  logic [30:0] x_new;
  logic [30:0] mul_a, mul_b;
  logic [61:0] prod_d;
  logic [31:0] prod_hi;
  logic [30:0] sin_m;
  logic signed [31:0] sin_v;
  logic signed [32:0] s_sum;
  logic [32:0] s_mag;
  logic [39:0] u40;
  logic [DIV_W-1:0]     div_num, quot;
  logic [DIV_DEN_W-1:0] div_den;
  logic        div_done;
  logic [31:0] off;
  logic signed [16:0] dmouse;
  logic signed [38:0] dmul;
  logic signed [39:0] p_raw, p_lim, p_clamp;
  logic [31:0] n_sel;

  assign op  = cmd_i.uop.op;
  assign arg = cmd_i.uop.arg;

  function automatic logic [30:0] mag31(logic signed [31:0] v);
    logic [31:0] a;
    a = v[31] ? 32'(-v) : 32'(v);
    return a[30:0];
  endfunction

  function automatic logic signed [32:0] term(logic signed [31:0] v, logic pos, logic neg);
    logic signed [32:0] e;
    e = {v[31], v};
    if (pos && !neg) begin
      return e;
    end else if (neg && !pos) begin
      return -e;
    end
    return '0;
  endfunction

  // Select angle and fold it into the first quadrant
  always_comb begin
    case (arg)
      SRC_SIN_YAW:   ang = yaw_q;
      SRC_COS_YAW:   ang = yaw_q + QUARTER_TURN;
      SRC_SIN_PITCH: ang = pitch_q;
      default:       ang = pitch_q + QUARTER_TURN;
    endcase
    x_new = ang[30] ? (ONE_Q30 - {1'b0, ang[29:0]}) : {1'b0, ang[29:0]};
  end

  // Shared multiplier operands
  always_comb begin
    case (op)
      OP_MUL_XX:  begin mul_a = x_q;  mul_b = x_q; end
      OP_MUL_X2T: begin mul_a = x2_q; mul_b = t_q; end
      OP_MUL_XT:  begin mul_a = x_q;  mul_b = t_q; end
      OP_MUL_PC:  begin
        mul_a = (arg == SRC_SIN_YAW) ? mag31(sy_q) : mag31(cy_q);
        mul_b = mag31(cp_q);
      end
      OP_MUL_L:   begin
        mul_a = look_dist_q;
        mul_b = (arg == FAC_PROD) ? prod_q[60:30] : mag31(sp_q);
      end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Sine result: limit to one, apply half-turn sign
  assign prod_hi = prod_q[61:30];
  assign sin_m   = (prod_hi > {1'b0, ONE_Q30}) ? ONE_Q30 : prod_hi[30:0];
  assign sin_v   = quad_q[1] ? -$signed({1'b0, sin_m}) : $signed({1'b0, sin_m});

  // Key-weighted step sums
  always_comb begin
    case (arg)
      AXIS_X:  s_sum = term(sy_q, item_q.key_back, item_q.key_front)
                     + term(cy_q, item_q.key_right, item_q.key_left);
      AXIS_Y:  s_sum = term(sp_q, item_q.key_front, item_q.key_back);
      default: s_sum = term(cy_q, item_q.key_back, item_q.key_front)
                     + term(sy_q, item_q.key_left, item_q.key_right);
    endcase
    s_mag = s_sum[32] ? 33'(-s_sum) : 33'(s_sum);
  end

  // Divider operands
  always_comb begin
    u40 = 40'(prod_q[61:LOOK_SHIFT]);
    if (arg == DIV_LOOK) begin
      div_num = (u40 << 3) + (u40 << 1);
      div_den = LOOK_DIVISOR;
    end else begin
      div_num = DIV_W'(s_mag >> MOVE_SHIFT);
      div_den = (mdiv_q == '0) ? DIV_DEN_W'(1) : mdiv_q;
    end
  end

  fpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op == OP_DIV),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign stat_o.div_done = div_done;
  assign off = sgn_q ? (32'd0 - quot[31:0]) : quot[31:0];

  // Mouse turn: one multiplier shared by yaw and pitch
  always_comb begin
    if (op == OP_ANG_PITCH) begin
      dmouse = $signed({1'b0, item_q.mouse_y}) - $signed({1'b0, lmy_q});
    end else begin
      dmouse = $signed({1'b0, item_q.mouse_x}) - $signed({1'b0, lmx_q});
    end
    dmul    = dmouse * $signed({1'b0, MOUSE_STEP});
    p_raw   = 40'($signed(pitch_q)) - 40'(dmul);
    p_lim   = $signed({8'd0, PITCH_LIM});
    if (p_raw > p_lim) begin
      p_clamp = p_lim;
    end else if (p_raw < -p_lim) begin
      p_clamp = -p_lim;
    end else begin
      p_clamp = p_raw;
    end
  end

  always_comb begin
    case (arg)
      AXIS_X:  n_sel = nx_q;
      AXIS_Y:  n_sel = ny_q;
      default: n_sel = nz_q;
    endcase
  end

  // Angle, mouse and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q       <= '0;
      pitch_q     <= '0;
      lmx_q       <= '0;
      lmy_q       <= '0;
      look_dist_q <= '0;
      eye_q       <= EYE_RESET;
      mdiv_q      <= MOVE_DIV_RESET;
    end else begin
      if (op == OP_ANG_YAW) begin
        yaw_q <= (yaw_q - dmul[31:0]) & ANG_MASK;
        lmx_q <= item_q.mouse_x;
      end
      if (op == OP_ANG_PITCH) begin
        pitch_q <= p_clamp[31:0] & ANG_MASK;
        lmy_q   <= item_q.mouse_y;
      end
      if (cfg_we_i) begin
        case (cfg_i.idx)
          CFG_INIT_YAW:      yaw_q       <= cfg_i.wdata & ANG_MASK;
          CFG_INIT_PITCH:    pitch_q     <= {cfg_i.wdata[30], cfg_i.wdata[30:0]} & ANG_MASK;
          CFG_LOOK_DISTANCE: look_dist_q <= cfg_i.wdata[30:0];
          CFG_EYE_HEIGHT:    eye_q       <= cfg_i.wdata;
          CFG_MOVE_DIVIDER:  mdiv_q      <= cfg_i.wdata[9:0];
          CFG_INIT_MOUSE_X:  lmx_q       <= cfg_i.wdata[15:0];
          CFG_INIT_MOUSE_Y:  lmy_q       <= cfg_i.wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers, driven by the current operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      item_q <= in_item_i;
    end
    case (op)
      OP_SIN_LD: begin
        quad_q <= ang[31:30];
        x_q    <= x_new;
      end
      OP_MUL_XX, OP_MUL_X2T, OP_MUL_XT, OP_MUL_L: prod_q <= prod_d;
      OP_MUL_PC: begin
        prod_q <= prod_d;
        sgn_q  <= ((arg == SRC_SIN_YAW) ? sy_q[31] : cy_q[31]) ^ cp_q[31];
      end
      OP_LD_X2: begin
        x2_q <= prod_q[60:30];
        t_q  <= A11;
      end
      OP_SUB_T: t_q <= sin_coef(arg) - prod_q[60:30];
      OP_SIN_ST: begin
        case (arg)
          SRC_SIN_YAW:   sy_q <= sin_v;
          SRC_COS_YAW:   cy_q <= sin_v;
          SRC_SIN_PITCH: sp_q <= sin_v;
          default:       cp_q <= sin_v;
        endcase
      end
      OP_DIV: begin
        if (arg != DIV_LOOK) begin
          sgn_q <= s_sum[32];
        end
      end
      OP_MOVE: begin
        case (arg)
          AXIS_X:  nx_q <= 32'(item_q.pos_x) + off;
          AXIS_Y:  ny_q <= 32'(item_q.pos_y) + off;
          default: nz_q <= 32'(item_q.pos_z) + off;
        endcase
      end
      OP_TGT: begin
        case (arg)
          AXIS_X:  tx_q <= n_sel - off;
          AXIS_Y:  ty_q <= n_sel - off;
          default: tz_q <= n_sel - off;
        endcase
      end
      OP_DONE: begin
        out_q.new_pos_x <= nx_q;
        out_q.new_pos_y <= item_q.force_eye_height ? eye_q : ny_q;
        out_q.new_pos_z <= nz_q;
        out_q.look_x    <= tx_q;
        out_q.look_y    <= ty_q;
        out_q.look_z    <= tz_q;
      end
      default: ;
    endcase
    // Upward look factor is -sin pitch: negative when pitch is positive
    if (op == OP_MUL_L && arg == FAC_PITCH) begin
      sgn_q <= !sp_q[31];
    end
  end

  assign out_item_o = out_q;

endmodule

// ----- sv/fpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpc_ctrl
// Sequencer: steps the micro-program and owns the frame and result handshakes.
// ----------------------------------------------------------------------------
`include "first_person_camera_update_defines.svh"

module fpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  fpc_pkg::dp_stat_t  stat_i,
  output fpc_pkg::dp_cmd_t   cmd_o
);
  import fpc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic            out_valid_q;
  uop_t            uop;
  logic            done_hold;

  assign uop       = ucode(pc_q);
  assign done_hold = (uop.op == OP_DONE) && out_valid_q && !out_ready_i;

  // Issue the current step; hold the final step while the result slot is full
  always_comb begin
    cmd_o.in_load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.uop.op  = OP_NOP;
    cmd_o.uop.arg = '0;
    if (state_q == ST_RUN && !done_hold) begin
      cmd_o.uop = uop;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer state, program counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.uop.op == OP_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            pc_q    <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          case (cmd_o.uop.op)
            OP_DIV: begin
              state_q <= ST_WAIT;
            end
            OP_SKIP: pc_q <= {pc_q[7:4] + 4'd1, 4'd0};
            OP_DONE: state_q <= ST_IDLE;
            default: begin
              if (!done_hold) begin
                pc_q <= pc_q + PC_W'(1);
              end
            end
          endcase
        end
        ST_WAIT: begin
          if (stat_i.div_done) begin
            pc_q    <= pc_q + PC_W'(1);
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `FPC_ASSERT(a_done_slot_free, (cmd_o.uop.op == OP_DONE) |-> (!out_valid_q || out_ready_i), "result overwritten before taken")
  `FPC_ASSERT(a_wait_in_div_seg, (state_q == ST_WAIT) |-> (pc_q[7:4] == SEG_MOVE || pc_q[7:4] == SEG_LOOK), "divide wait outside move or look segment")
  `FPC_ASSERT(a_div_done_waiting, stat_i.div_done |-> (state_q == ST_WAIT), "divider finished while not waiting")
  `FPC_ASSERT_NEXT(a_done_sets_valid, cmd_o.uop.op == OP_DONE, out_valid_q, "result not presented after final step")

endmodule

// ----- sv/first_person_camera_update.sv -----
// ----------------------------------------------------------------------------
// first_person_camera_update
// Per-frame camera move, mouse turn and look target, sequenced datapath.
// ----------------------------------------------------------------------------
//  channel  | role   | beat
//  ---------+--------+---------------------------------------------------
//  in_i     | sink   | position, mouse, keys, eye-height flag (one frame)
//  out_o    | source | new position and look target
//  cfg_i    | sink   | register index and write data, always ready
//
//  Each frame runs seven sines on the one shared 31x31 multiplier and six
//  divides on the 4-bit-per-cycle divider. A new frame is accepted once the
//  previous one has left the sequencer; its result may still wait in the
//  output register. A stalled output holds the final step only. Reset is
//  asynchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module first_person_camera_update (
  input  logic          clk_i,
  input  logic          rst_ni,
  fpc_stream_if.sink    in_i,
  fpc_stream_if.source  out_o,
  fpc_stream_if.sink    cfg_i
);
  import fpc_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  in_item_t  in_item;
  cfg_wr_t   cfg_wr;
  out_item_t out_item;
  logic      cfg_we;

  assign in_item     = in_i.data;
  assign cfg_wr      = cfg_i.data;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign out_o.data  = out_item;

  fpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fpc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_item_i  (in_item),
    .cfg_we_i   (cfg_we),
    .cfg_i      (cfg_wr),
    .out_item_o (out_item)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-person camera update. Frames go through
// random valid/ready stalls. An in-bench camera model predicts the result beats
// but for typed rows, which give their own, and each result beat is compared
// field by field. The run sweeps register settings and each register's extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import fpc_pkg::*;

  localparam int  RAND_PER_PHASE = 165;
  localparam int  QUIET_TAIL     = 100;
  localparam int  DRAIN_CYCLES   = 400;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fpc_stream_if #(.T(in_item_t))  in_if ();
  fpc_stream_if #(.T(out_item_t)) out_if ();
  fpc_stream_if #(.T(cfg_wr_t))   cfg_if ();

  logic      frame_valid = 1'b0;
  in_item_t  frame_beat = '0;
  logic      view_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  cfg_wr_t   cfg_beat = '0;

  assign in_if.valid  = frame_valid;
  assign in_if.data   = frame_beat;
  assign out_if.ready = view_ready;
  assign cfg_if.valid = cfg_valid;
  assign cfg_if.data  = cfg_beat;

  first_person_camera_update uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Camera model: registers and running state
  logic [31:0] m_init_yaw = '0;
  logic [30:0] m_init_pitch = '0;
  logic [30:0] m_look_dist = '0;
  logic [31:0] m_eye_height = EYE_RESET;
  logic [9:0]  m_move_div = MOVE_DIV_RESET;
  logic [31:0] cam_yaw = '0;
  logic [31:0] cam_pitch = '0;
  logic [15:0] prev_mx = '0;
  logic [15:0] prev_my = '0;

  out_item_t pending_views[$];
  int        mismatches = 0;
  int        frames_sent = 0;
  int        views_seen = 0;
  int        cfg_writes = 0;
  longint    cycle_count = 0;
  bit        quiet = 1'b0;
  bit        running = 1'b0;
  int        rx_stall = 0;

  // Polynomial sine magnitude, Q30
  function automatic longint unsigned sine_mag(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = (x * x) >> 30;
    t  = longint'(A11);
    t  = longint'(A9) - ((x2 * t) >> 30);
    t  = longint'(A7) - ((x2 * t) >> 30);
    t  = longint'(A5) - ((x2 * t) >> 30);
    t  = longint'(A3) - ((x2 * t) >> 30);
    t  = longint'(A1) - ((x2 * t) >> 30);
    t  = (x * t) >> 30;
    return (t > (64'd1 << 30)) ? (64'd1 << 30) : t;
  endfunction

  function automatic longint sine(logic [31:0] a);
    longint unsigned f;
    longint unsigned m;
    f = longint'(a[29:0]);
    m = sine_mag(a[30] ? ((64'd1 << 30) - f) : f);
    return a[31] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint cosine(logic [31:0] a);
    return sine(a + QUARTER_TURN);
  endfunction

  function automatic longint unsigned magn(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Sign-magnitude Q30 product
  function automatic longint q30_mul(longint a, longint b);
    longint m;
    m = longint'((magn(a) * magn(b)) >> 30);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  // Per-axis move, truncated toward zero
  function automatic logic [31:0] move_len(longint s, logic [9:0] dv);
    longint den;
    longint num;
    den = longint'(dv) <<< 30;
    num = s * 65536;
    return 32'(num / den);
  endfunction

  function automatic logic [31:0] look_offset(longint p);
    longint unsigned u;
    longint unsigned o;
    u = (longint'(m_look_dist) * magn(p)) >> 26;
    o = (u * 10) / 816;
    return (p < 0) ? 32'(-o) : 32'(o);
  endfunction

  function automatic void load_pitch();
    cam_pitch = {m_init_pitch[30], m_init_pitch} & ANG_MASK;
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    case (idx)
      CFG_INIT_YAW:      begin m_init_yaw = v; cam_yaw = v & ANG_MASK; end
      CFG_INIT_PITCH:    begin m_init_pitch = v[30:0]; load_pitch(); end
      CFG_LOOK_DISTANCE: m_look_dist = v[30:0];
      CFG_EYE_HEIGHT:    m_eye_height = v;
      CFG_MOVE_DIVIDER:  m_move_div = v[9:0];
      CFG_INIT_MOUSE_X:  prev_mx = v[15:0];
      CFG_INIT_MOUSE_Y:  prev_my = v[15:0];
      default:           ;
    endcase
  endfunction

  // Move, turn, then build the look target for one frame
  function automatic out_item_t advance_camera(in_item_t it);
    out_item_t   r;
    logic [9:0]  dv;
    longint      fr, bk, rt, lf, sy, cy, sp, cp, dx, dy, p, lim;
    logic [31:0] ny;
    dv = (m_move_div == 0) ? 10'd1 : m_move_div;
    fr = it.key_front; bk = it.key_back; rt = it.key_right; lf = it.key_left;
    sy = sine(cam_yaw);
    cy = cosine(cam_yaw);
    sp = sine(cam_pitch);
    r.new_pos_x = it.pos_x + move_len(sy * (bk - fr) + cy * (rt - lf), dv);
    ny          = it.pos_y + move_len(sp * (fr - bk), dv);
    r.new_pos_z = it.pos_z + move_len(cy * (bk - fr) + sy * (lf - rt), dv);

    dx = longint'(it.mouse_x) - longint'(prev_mx);
    dy = longint'(it.mouse_y) - longint'(prev_my);
    prev_mx = it.mouse_x;
    prev_my = it.mouse_y;
    cam_yaw = (cam_yaw - 32'(dx * longint'(MOUSE_STEP))) & ANG_MASK;
    lim = longint'(PITCH_LIM);
    p = longint'(signed'(cam_pitch)) - dy * longint'(MOUSE_STEP);
    if (p > lim) p = lim;
    else if (p < -lim) p = -lim;
    cam_pitch = 32'(p) & ANG_MASK;

    sy = sine(cam_yaw);
    cy = cosine(cam_yaw);
    sp = sine(cam_pitch);
    cp = cosine(cam_pitch);
    r.look_x = r.new_pos_x - look_offset(q30_mul(sy, cp));
    r.look_y = ny - look_offset(-sp);
    r.look_z = r.new_pos_z - look_offset(q30_mul(cy, cp));
    r.new_pos_y = it.force_eye_height ? m_eye_height : ny;
    return r;
  endfunction

  // Drive one frame beat; the expectation is pushed at acceptance
  task automatic send_frame(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    frame_valid <= 1'b1;
    frame_beat  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pred = advance_camera(it);
    pending_views.push_back(typed ? typed_res : pred);
    frames_sent++;
  endtask

  // Write one register; valid stays high for back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_beat  <= '{idx: idx, wdata: v};
    do @(posedge clk_i); while (!cfg_if.ready);
    model_write(idx, v);
    cfg_writes++;
  endtask

  task automatic wait_drained();
    frame_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  // Random frame: mostly small mouse motion, some large jumps
  function automatic in_item_t rand_frame();
    in_item_t it;
    int       sel;
    it.pos_x = $urandom;
    it.pos_y = $urandom;
    it.pos_z = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      it.mouse_x = prev_mx + 16'($urandom_range(0, 100) - 50);
      it.mouse_y = prev_my + 16'($urandom_range(0, 100) - 50);
    end else if (sel < 9) begin
      it.mouse_x = $urandom;
      it.mouse_y = $urandom;
    end else begin
      it.mouse_x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      it.mouse_y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    {it.key_front, it.key_back, it.key_right, it.key_left} = 4'($urandom);
    it.force_eye_height = $urandom_range(0, 1);
    return it;
  endfunction

  // Cycle counter and watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_views.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Check result beats and stall the result side in short bursts
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (running) begin
      if (out_if.valid && view_ready) begin
        got = out_if.data;
        views_seen++;
        if (pending_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          want = pending_views.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (got[191 - 32*k -: 32] !== want[191 - 32*k -: 32]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("result %0d field %0d: expected %h, got %h", views_seen, k,
                         want[191 - 32*k -: 32], got[191 - 32*k -: 32]);
            end
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        view_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rx_stall <= $urandom_range(0, 2);
        view_ready <= 1'b0;
      end else begin
        view_ready <= 1'b1;
      end
    end
  end

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } frame_row_t;

  function automatic frame_row_t row(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                     logic [15:0] mx, logic [15:0] my, logic [3:0] keys,
                                     bit force_y);
    frame_row_t r;
    r.it = '{pos_x: px, pos_y: py, pos_z: pz, mouse_x: mx, mouse_y: my,
             key_front: keys[3], key_back: keys[2], key_right: keys[1],
             key_left: keys[0], force_eye_height: force_y};
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  // Stimulus
  initial begin
    frame_row_t  rows[$];
    frame_row_t  rw;
    logic [31:0] cfg_set[7];
    int          n_phases;
    int          n_rand;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    running = 1'b1;

    // After reset with zero distance the frame passes through unchanged, bar a forced eye height
    rw = row('0, '0, '0, '0, '0, 4'b0000, 1'b0);
    rw.typed = 1'b1; rw.res = '0;
    rows.push_back(rw);
    rw = row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, 4'b0000, 1'b1);
    rw.typed = 1'b1;
    rw.res = '{32'h7FFF_FFFF, EYE_RESET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF};
    rows.push_back(rw);
    rw = row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, 4'b0000, 1'b0);
    rw.typed = 1'b1;
    rw.res = {6{32'h8000_0000}};
    rows.push_back(rw);
    // Each key alone, an opposing pair, all keys; wrap near the position limits
    rows.push_back(row(32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000, '0, '0, 4'b1000, 1'b0));
    rows.push_back(row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, 4'b0100, 1'b0));
    rows.push_back(row('0, '0, '0, '0, '0, 4'b0010, 1'b0));
    rows.push_back(row('0, '0, '0, '0, '0, 4'b0001, 1'b1));
    rows.push_back(row('0, '0, '0, '0, '0, 4'b1100, 1'b0));
    rows.push_back(row('0, '0, '0, '0, '0, 4'b1111, 1'b0));
    // Largest mouse jumps; pitch runs into both clamps, yaw wraps
    rows.push_back(row(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 16'hFFFF, 16'hFFFF,
                       4'b1010, 1'b0));
    rows.push_back(row(32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 4'b0101, 1'b1));
    rows.push_back(row('0, '0, '0, 16'h0001, 16'h8000, 4'b1000, 1'b0));
    rows.push_back(row('0, '0, '0, 16'h0800, 16'h0000, 4'b0100, 1'b0));
    rows.push_back(row(32'h0000_FFFF, 32'hFFFF_0000, 32'h5555_AAAA, 16'h7FFF, 16'h7FFF,
                       4'b1001, 1'b1));
    foreach (rows[i]) send_frame(rows[i].it, rows[i].typed, rows[i].res);
    wait_drained();

    // Register settings per phase, extremes included
    n_phases = 7;
    for (int ph = 0; ph < n_phases; ph++) begin
      case (ph)
        0: cfg_set = '{32'h2000_0000, 32'h1000_0000, 32'h0014_0000, 32'h0002_0000,
                       32'd25, 32'd100, 32'd200};
        1: cfg_set = '{32'hFFFF_FFFF, 32'd1061673041, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'd0, 32'hFFFF, 32'hFFFF};
        2: cfg_set = '{32'h0000_0000, 32'(-1061673041), 32'h0000_0000, 32'h7FFF_FFFF,
                       32'd1023, 32'h0000, 32'h0000};
        3: cfg_set = '{$urandom, 32'h3FFF_FFFF, $urandom_range(0, 32'h7FFF_FFFF), $urandom,
                       32'd1, $urandom_range(0, 65535), $urandom_range(0, 65535)};
        4: cfg_set = '{$urandom, 32'h4000_0000, 32'h0100_0000, $urandom,
                       32'd2, $urandom_range(0, 65535), $urandom_range(0, 65535)};
        default: cfg_set = '{$urandom, 32'($urandom_range(0, 2123346082) - 1061673041),
                             $urandom_range(0, 32'h7FFF_FFFF), $urandom,
                             $urandom_range(1, 1023), $urandom_range(0, 65535),
                             $urandom_range(0, 65535)};
      endcase
      write_reg(CFG_INIT_YAW,      cfg_set[0]);
      write_reg(CFG_INIT_PITCH,    cfg_set[1]);
      write_reg(CFG_LOOK_DISTANCE, cfg_set[2]);
      write_reg(CFG_EYE_HEIGHT,    cfg_set[3]);
      write_reg(CFG_MOVE_DIVIDER,  cfg_set[4]);
      write_reg(CFG_INIT_MOUSE_X,  cfg_set[5]);
      write_reg(CFG_INIT_MOUSE_Y,  cfg_set[6]);
      cfg_valid <= 1'b0;
      @(posedge clk_i);

      // Last phase runs its tail with no idling on either side
      n_rand = (ph == n_phases - 1) ? RAND_PER_PHASE + QUIET_TAIL : RAND_PER_PHASE;
      for (int i = 0; i < n_rand; i++) begin
        if (ph == n_phases - 1 && i == RAND_PER_PHASE) quiet = 1'b1;
        send_frame(rand_frame(), 1'b0, '0);
      end
      // Hold the sender until every result of the phase is back
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d frames, %0d results, %0d register writes over %0d settings",
             frames_sent, views_seen, cfg_writes, n_phases + 1);
    $display("%0d field mismatches", mismatches);
    if (mismatches == 0 && pending_views.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
